/* hdl/scv_pkg.sv */
`timescale 1ns / 1ps

package scv_pkg;

  // chord slot and scale geometry
  localparam int NUM_SLOTS   = 7;
  localparam int DEGREES     = 7;
  localparam int OCTAVE      = 12;
  localparam int MODE_ROWS   = 10;
  localparam int QUEUE_DEPTH = 2;

  // field widths fixed by the interface
  localparam int CHORD_W = 6;
  localparam int COUNT_W = 3;
  localparam int CHAR_W  = 8;
  localparam int PITCH_W = 7;
  localparam int SLOT_W  = 3;
  localparam int CFG_W   = 4;
  localparam int CFGIX_W = 2;

  // register indexes
  localparam logic [CFGIX_W-1:0] REG_KEY  = 2'd0;
  localparam logic [CFGIX_W-1:0] REG_MODE = 2'd1;

  localparam logic [CHAR_W-1:0] SKIP_CHAR = 8'h2D;

  // bias that keeps step numbers non-negative before the divide by seven
  localparam logic [6:0] STEP_BIAS = 7'd42;
  localparam int         BIAS_OCT  = 6;

  // semitones of each scale step above degree one, per mode
  localparam logic [3:0] SCALE_TAB [MODE_ROWS][DEGREES] = '{
    '{4'd0, 4'd2, 4'd4, 4'd5, 4'd7, 4'd9,  4'd11},
    '{4'd0, 4'd2, 4'd3, 4'd5, 4'd7, 4'd9,  4'd10},
    '{4'd0, 4'd1, 4'd3, 4'd5, 4'd7, 4'd8,  4'd10},
    '{4'd0, 4'd2, 4'd4, 4'd6, 4'd7, 4'd9,  4'd11},
    '{4'd0, 4'd2, 4'd4, 4'd5, 4'd7, 4'd9,  4'd10},
    '{4'd0, 4'd2, 4'd3, 4'd5, 4'd7, 4'd8,  4'd10},
    '{4'd0, 4'd1, 4'd3, 4'd5, 4'd6, 4'd8,  4'd10},
    '{4'd0, 4'd2, 4'd3, 4'd5, 4'd7, 4'd9,  4'd11},
    '{4'd0, 4'd2, 4'd3, 4'd5, 4'd7, 4'd8,  4'd11},
    '{4'd0, 4'd2, 4'd4, 4'd6, 4'd8, 4'd10, 4'd12}
  };

  // decoded tweak: scale steps to move, fixed semitone shift, unknown flag
  typedef struct packed {
    logic signed [2:0] steps;
    logic signed [4:0] shift;
    logic              bad;
  } tweak_t;

  // one classified chord waiting for the note emitter
  typedef struct packed {
    logic signed [PITCH_W-1:0]          root;
    logic signed [7:0]                  sbase;
    logic signed [6:0]                  base;
    logic [NUM_SLOTS-1:0]               mask;
    logic [NUM_SLOTS-1:0]               bad;
    logic [NUM_SLOTS-1:0][2:0]          steps;
    logic [NUM_SLOTS-1:0][4:0]          shift;
  } entry_t;

  // semitones of zero-based step n above degree one, octave carry included
  // n stays within -36..45, so n + 42 fits 7 bits and x*37>>8 is floor(x/7)
  function automatic logic signed [7:0] step_semis(input logic [3:0] row,
                                                   input logic signed [6:0] n);
    logic [6:0]        x;
    logic [12:0]       prod;
    logic [3:0]        q;
    logic [6:0]        rem;
    logic signed [7:0] oct;
    x    = n + STEP_BIAS;
    prod = 13'(x) * 13'd37;
    q    = prod[11:8];
    rem  = x - 7'(q) * 7'd7;
    oct  = $signed({4'b0, q}) - 8'(BIAS_OCT);
    return $signed({4'b0, SCALE_TAB[row][rem[2:0]]}) + 8'(oct * 8'sd12);
  endfunction

  // tweak character decode
  function automatic tweak_t tweak_decode(input logic [CHAR_W-1:0] ch);
    tweak_t t;
    t = '{steps: 3'sd0, shift: 5'sd0, bad: 1'b0};
    unique case (ch)
      "x", "y": ;
      "X": t.shift = 5'sd12;
      "Y": t.shift = -5'sd12;
      "s": t.shift = 5'sd1;
      "S": t.shift = 5'sd2;
      "u": t.shift = 5'sd3;
      "U": t.shift = 5'sd4;
      "b": t.shift = -5'sd1;
      "B": t.shift = -5'sd2;
      "d": t.shift = -5'sd3;
      "D": t.shift = -5'sd4;
      "n": t.steps = 3'sd1;
      "N": begin t.steps = 3'sd1; t.shift = 5'sd12; end
      "m": t.steps = 3'sd2;
      "M": begin t.steps = 3'sd2; t.shift = 5'sd12; end
      "l": t.steps = 3'sd3;
      "L": begin t.steps = 3'sd3; t.shift = 5'sd12; end
      "p": t.steps = -3'sd1;
      "P": begin t.steps = -3'sd1; t.shift = -5'sd12; end
      "q": t.steps = -3'sd2;
      "Q": begin t.steps = -3'sd2; t.shift = -5'sd12; end
      "r": t.steps = -3'sd3;
      "R": begin t.steps = -3'sd3; t.shift = -5'sd12; end
      default: t.bad = 1'b1;
    endcase
    return t;
  endfunction

endpackage

/* hdl/scv_front.sv */
`timescale 1ns / 1ps

module scv_front #(
  parameter int MAX_SLOTS = scv_pkg::NUM_SLOTS
) (
  input  logic                                            clk,
  input  logic                                            rst_n,
  input  logic                                            cfg_we,
  input  logic [scv_pkg::CFGIX_W-1:0]                     cfg_index,
  input  logic [scv_pkg::CFG_W-1:0]                       cfg_data,
  input  logic signed [scv_pkg::CHORD_W-1:0]              chord_number,
  input  logic [scv_pkg::COUNT_W-1:0]                     tweak_count,
  input  logic [scv_pkg::NUM_SLOTS-1:0][scv_pkg::CHAR_W-1:0] tweaks,
  output logic [3:0]                                      row,
  output scv_pkg::entry_t                                 entry
);
  import scv_pkg::*;

  logic [CFG_W-1:0]  key_pitch_r;
  logic [CFG_W-1:0]  scale_mode_r;
  logic [3:0]        key;
  logic signed [7:0] sbase;
  tweak_t            tw [NUM_SLOTS];

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_pitch_r  <= '0;
      scale_mode_r <= '0;
    end else if (cfg_we) begin
      if (cfg_index == REG_KEY) begin
        key_pitch_r <= cfg_data;
      end else if (cfg_index == REG_MODE) begin
        scale_mode_r <= cfg_data;
      end
    end
  end

  // out-of-range mode falls back to the major row, key folds into one octave
  assign row = (scale_mode_r < 4'(MODE_ROWS)) ? scale_mode_r : 4'd0;
  assign key = (key_pitch_r >= 4'(OCTAVE)) ? key_pitch_r - 4'(OCTAVE) : key_pitch_r;

  // chord root
  assign entry.base  = 7'(chord_number) - 7'sd1;
  assign sbase       = step_semis(row, entry.base);
  assign entry.sbase = sbase;
  assign entry.root  = PITCH_W'(sbase + $signed({4'b0, key}));

  // classify every slot in parallel
  for (genvar i = 0; i < NUM_SLOTS; i++) begin : g_slot
    assign tw[i] = tweak_decode(tweaks[i]);
    assign entry.mask[i]  = (i < MAX_SLOTS) && (COUNT_W'(i) < tweak_count) &&
                            (tweaks[i] != SKIP_CHAR);
    assign entry.bad[i]   = tw[i].bad;
    assign entry.steps[i] = tw[i].steps;
    assign entry.shift[i] = tw[i].shift;
  end

endmodule

/* hdl/scv_queue.sv */
`timescale 1ns / 1ps

module scv_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  scv_pkg::entry_t push_entry,
  input  logic            pop,
  output scv_pkg::entry_t head,
  output logic            empty,
  output logic            full
);
  import scv_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  entry_t           store_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             do_pop;

  assign empty  = (count_r == '0);
  assign full   = (count_r == CNT_W'(QUEUE_DEPTH));
  assign head   = store_r[rd_ptr_r];
  assign do_pop = pop && !empty;

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      store_r[wr_ptr_r] <= push_entry;
    end
  end

endmodule

/* hdl/scv_back.sv */
`timescale 1ns / 1ps

module scv_back (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic [3:0]                           row,
  input  scv_pkg::entry_t                      head,
  input  logic                                 empty,
  output logic                                 pop,
  output logic                                 out_valid,
  output logic signed [scv_pkg::PITCH_W-1:0]   out_root_pitch,
  output logic signed [scv_pkg::PITCH_W-1:0]   out_note_offset,
  output logic [scv_pkg::SLOT_W-1:0]           out_slot_index,
  output logic                                 out_is_rest,
  output logic                                 out_bad_tweak,
  output logic                                 out_last
);
  import scv_pkg::*;

  logic                      started_r;
  logic [NUM_SLOTS-1:0]      rem_r;
  logic                      valid_r;
  logic signed [PITCH_W-1:0] root_r;
  logic signed [PITCH_W-1:0] note_r;
  logic [SLOT_W-1:0]         slot_r;
  logic                      rest_r;
  logic                      bad_r;
  logic                      last_r;

  logic [NUM_SLOTS-1:0]      cur_mask;
  logic [NUM_SLOTS-1:0]      next_mask;
  logic [SLOT_W-1:0]         k;
  logic                      rest;
  logic signed [6:0]         step;
  logic signed [7:0]         semis;
  logic signed [9:0]         note;

  // slots left of the chord at the head of the queue
  assign cur_mask = started_r ? rem_r : head.mask;
  assign rest     = (cur_mask == '0);

  // lowest remaining slot
  always_comb begin
    k = '0;
    for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
      if (cur_mask[i]) begin
        k = SLOT_W'(i);
      end
    end
    next_mask    = cur_mask;
    next_mask[k] = 1'b0;
  end

  // note offset: scale step of the slot, moved by the tweak, minus the root
  always_comb begin
    step  = head.base + 7'({k, 1'b0}) + 7'($signed(head.steps[k]));
    semis = step_semis(row, step);
    note  = 10'(semis) - 10'(head.sbase) + 10'($signed(head.shift[k]));
  end

  assign pop = !empty && (rest || next_mask == '0);

  // slot walk and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      started_r <= 1'b0;
      rem_r     <= '0;
      valid_r   <= 1'b0;
    end else begin
      valid_r <= !empty;
      if (!empty) begin
        if (pop) begin
          started_r <= 1'b0;
        end else begin
          started_r <= 1'b1;
          rem_r     <= next_mask;
        end
        root_r <= head.root;
        note_r <= rest ? '0 : PITCH_W'(note);
        slot_r <= rest ? '0 : k;
        rest_r <= rest;
        bad_r  <= rest ? 1'b0 : head.bad[k];
        last_r <= pop;
      end
    end
  end

  assign out_valid       = valid_r;
  assign out_root_pitch  = root_r;
  assign out_note_offset = note_r;
  assign out_slot_index  = slot_r;
  assign out_is_rest     = rest_r;
  assign out_bad_tweak   = bad_r;
  assign out_last        = last_r;

endmodule

/* hdl/scale_chord_voicer.sv */
`timescale 1ns / 1ps

// channel   | ports                                  | handshake
// ----------+----------------------------------------+---------------------------
// input     | in_chord_number, in_tweak_count/_0.._6 | start high, busy low
// result    | out_root_pitch .. out_last             | out_valid for one cycle
// config    | cfg_index, cfg_data                    | cfg_we, taken at once
//
// An accepted chord is classified in the cycle it arrives and stored in a
// two-entry queue; the note emitter takes one slot per cycle. With the
// queue empty, an accepted chord is written into the queue and its first
// word then passes through the result register to the outputs. busy rises
// only while the queue is full.
// Reset clears the registers to key 0, mode 0 and empties the queue.
// The receiver cannot stall, so the emitter never waits on the output.
module scale_chord_voicer #(
  parameter int MAX_SLOTS = scv_pkg::NUM_SLOTS
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  output logic                                 busy,
  input  logic signed [scv_pkg::CHORD_W-1:0]   in_chord_number,
  input  logic [scv_pkg::COUNT_W-1:0]          in_tweak_count,
  input  logic [scv_pkg::CHAR_W-1:0]           in_tweak_0,
  input  logic [scv_pkg::CHAR_W-1:0]           in_tweak_1,
  input  logic [scv_pkg::CHAR_W-1:0]           in_tweak_2,
  input  logic [scv_pkg::CHAR_W-1:0]           in_tweak_3,
  input  logic [scv_pkg::CHAR_W-1:0]           in_tweak_4,
  input  logic [scv_pkg::CHAR_W-1:0]           in_tweak_5,
  input  logic [scv_pkg::CHAR_W-1:0]           in_tweak_6,
  input  logic                                 cfg_we,
  input  logic [scv_pkg::CFGIX_W-1:0]          cfg_index,
  input  logic [scv_pkg::CFG_W-1:0]            cfg_data,
  output logic                                 out_valid,
  output logic signed [scv_pkg::PITCH_W-1:0]   out_root_pitch,
  output logic signed [scv_pkg::PITCH_W-1:0]   out_note_offset,
  output logic [scv_pkg::SLOT_W-1:0]           out_slot_index,
  output logic                                 out_is_rest,
  output logic                                 out_bad_tweak,
  output logic                                 out_last
);
  import scv_pkg::*;

  logic [NUM_SLOTS-1:0][CHAR_W-1:0] tweaks;
  logic [3:0]                       row;
  entry_t                           new_entry;
  entry_t                           head;
  logic                             push;
  logic                             pop;
  logic                             empty;
  logic                             full;

  assign tweaks = {in_tweak_6, in_tweak_5, in_tweak_4, in_tweak_3,
                   in_tweak_2, in_tweak_1, in_tweak_0};

  assign busy = full;
  assign push = start && !full;

  // classify and hold configuration
  scv_front #(
    .MAX_SLOTS(MAX_SLOTS)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .chord_number (in_chord_number),
    .tweak_count  (in_tweak_count),
    .tweaks       (tweaks),
    .row          (row),
    .entry        (new_entry)
  );

  // decoupling queue
  scv_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (new_entry),
    .pop        (pop),
    .head       (head),
    .empty      (empty),
    .full       (full)
  );

  // note emitter
  scv_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .row             (row),
    .head            (head),
    .empty           (empty),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_root_pitch  (out_root_pitch),
    .out_note_offset (out_note_offset),
    .out_slot_index  (out_slot_index),
    .out_is_rest     (out_is_rest),
    .out_bad_tweak   (out_bad_tweak),
    .out_last        (out_last)
  );

endmodule

/* tb/sv/scale_chord_voicer_tb.sv */
`timescale 1ns / 1ps

module scale_chord_voicer_tb;

  import scv_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int REPORT_MAX  = 10;
  localparam int DRAIN_MAX   = 5000;

  // register indexes that decode to nothing
  localparam logic [CFGIX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [CFGIX_W-1:0] REG_SPARE_B = 2'd3;

  // one expected voicing word
  typedef struct packed {
    logic [PITCH_W-1:0] root;
    logic [PITCH_W-1:0] offset;
    logic [SLOT_W-1:0]  slot;
    logic               rest;
    logic               bad;
    logic               last;
  } voice_t;

  logic                      clk;
  logic                      rst_n;
  logic                      start;
  logic                      busy;
  logic signed [CHORD_W-1:0] in_chord_number;
  logic [COUNT_W-1:0]        in_tweak_count;
  logic [CHAR_W-1:0]         in_tweak_0;
  logic [CHAR_W-1:0]         in_tweak_1;
  logic [CHAR_W-1:0]         in_tweak_2;
  logic [CHAR_W-1:0]         in_tweak_3;
  logic [CHAR_W-1:0]         in_tweak_4;
  logic [CHAR_W-1:0]         in_tweak_5;
  logic [CHAR_W-1:0]         in_tweak_6;
  logic                      cfg_we;
  logic [CFGIX_W-1:0]        cfg_index;
  logic [CFG_W-1:0]          cfg_data;
  logic                      out_valid;
  logic signed [PITCH_W-1:0] out_root_pitch;
  logic signed [PITCH_W-1:0] out_note_offset;
  logic [SLOT_W-1:0]         out_slot_index;
  logic                      out_is_rest;
  logic                      out_bad_tweak;
  logic                      out_last;

  // mirror of the key and mode registers
  logic [CFG_W-1:0] key_mirror;
  logic [CFG_W-1:0] mode_mirror;

  voice_t expected_voices[$];
  int     mismatch_count;
  int     cycle_count;

  // tweak characters the block knows
  string  known_tweaks = "xyXYsSuUbBdDnNmMlLpPqQrR";

  scale_chord_voicer i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_chord_number (in_chord_number),
    .in_tweak_count  (in_tweak_count),
    .in_tweak_0      (in_tweak_0),
    .in_tweak_1      (in_tweak_1),
    .in_tweak_2      (in_tweak_2),
    .in_tweak_3      (in_tweak_3),
    .in_tweak_4      (in_tweak_4),
    .in_tweak_5      (in_tweak_5),
    .in_tweak_6      (in_tweak_6),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .out_valid       (out_valid),
    .out_root_pitch  (out_root_pitch),
    .out_note_offset (out_note_offset),
    .out_slot_index  (out_slot_index),
    .out_is_rest     (out_is_rest),
    .out_bad_tweak   (out_bad_tweak),
    .out_last        (out_last)
  );

  // clock
  always #5 clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("scale_chord_voicer verification failed");
      $finish;
    end
  end

  // semitones of scale degree deg (0..6) in mode row
  function automatic int mode_interval(int row, int deg);
    logic [6:0][3:0] iv;
    case (row)
      1:       iv = {4'd10, 4'd9,  4'd7, 4'd5, 4'd3, 4'd2, 4'd0};
      2:       iv = {4'd10, 4'd8,  4'd7, 4'd5, 4'd3, 4'd1, 4'd0};
      3:       iv = {4'd11, 4'd9,  4'd7, 4'd6, 4'd4, 4'd2, 4'd0};
      4:       iv = {4'd10, 4'd9,  4'd7, 4'd5, 4'd4, 4'd2, 4'd0};
      5:       iv = {4'd10, 4'd8,  4'd7, 4'd5, 4'd3, 4'd2, 4'd0};
      6:       iv = {4'd10, 4'd8,  4'd6, 4'd5, 4'd3, 4'd1, 4'd0};
      7:       iv = {4'd11, 4'd9,  4'd7, 4'd5, 4'd3, 4'd2, 4'd0};
      8:       iv = {4'd11, 4'd8,  4'd7, 4'd5, 4'd3, 4'd2, 4'd0};
      9:       iv = {4'd12, 4'd10, 4'd8, 4'd6, 4'd4, 4'd2, 4'd0};
      default: iv = {4'd11, 4'd9,  4'd7, 4'd5, 4'd4, 4'd2, 4'd0};
    endcase
    return int'(iv[deg]);
  endfunction

  // semitones of zero-based step n above degree one, with octave carry
  function automatic int degree_semis(int row, int n);
    int m;
    m = n + 10 * DEGREES;
    return mode_interval(row, m % DEGREES) + OCTAVE * (m / DEGREES - 10);
  endfunction

  // semitones from step a to step a + d
  function automatic int step_span(int row, int a, int d);
    return degree_semis(row, a + d) - degree_semis(row, a);
  endfunction

  // semitone value of one tweak character at a given step
  function automatic int tweak_semis(int row, int step, logic [CHAR_W-1:0] ch,
                                     output logic bad);
    bad = 1'b0;
    case (ch)
      "x", "y": return 0;
      "X":      return OCTAVE;
      "Y":      return -OCTAVE;
      "s":      return 1;
      "S":      return 2;
      "u":      return 3;
      "U":      return 4;
      "b":      return -1;
      "B":      return -2;
      "d":      return -3;
      "D":      return -4;
      "n":      return step_span(row, step, 1);
      "N":      return step_span(row, step, 1) + OCTAVE;
      "m":      return step_span(row, step, 2);
      "M":      return step_span(row, step, 2) + OCTAVE;
      "l":      return step_span(row, step, 3);
      "L":      return step_span(row, step, 3) + OCTAVE;
      "p":      return step_span(row, step, -1);
      "P":      return step_span(row, step, -1) - OCTAVE;
      "q":      return step_span(row, step, -2);
      "Q":      return step_span(row, step, -2) - OCTAVE;
      "r":      return step_span(row, step, -3);
      "R":      return step_span(row, step, -3) - OCTAVE;
      default: begin
        bad = 1'b1;
        return 0;
      end
    endcase
  endfunction

  // expected words for one chord, queued in emission order
  task automatic predict_voicing(logic signed [CHORD_W-1:0] chord,
                                 logic [COUNT_W-1:0] count,
                                 logic [NUM_SLOTS-1:0][CHAR_W-1:0] tweaks);
    int     row;
    int     key;
    int     base;
    int     root;
    int     note;
    int     i;
    logic   bad;
    voice_t held;
    logic   have_held;
    row = (mode_mirror < MODE_ROWS) ? int'(mode_mirror) : 0;
    key = int'(key_mirror) % OCTAVE;
    base = int'(chord) - 1;
    root = key + degree_semis(row, base);
    have_held = 1'b0;
    for (i = 0; i < int'(count) && i < NUM_SLOTS; i++) begin
      if (tweaks[i] != SKIP_CHAR) begin
        note = step_span(row, base, 2 * i) + tweak_semis(row, base + 2 * i, tweaks[i], bad);
        if (have_held)
          expected_voices.push_back(held);
        held = {PITCH_W'(root), PITCH_W'(note), SLOT_W'(i), 1'b0, bad, 1'b0};
        have_held = 1'b1;
      end
    end
    // no note selected: one rest word
    if (!have_held)
      held = {PITCH_W'(root), PITCH_W'(0), SLOT_W'(0), 1'b1, 1'b0, 1'b0};
    held.last = 1'b1;
    expected_voices.push_back(held);
  endtask

  // idle gap: mostly short, a few long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50)
      return 0;
    else if (r < 85)
      return $urandom_range(1, 3);
    else if (r < 95)
      return $urandom_range(4, 8);
    return $urandom_range(15, 40);
  endfunction

  // send one chord word; starts and ends at a falling edge
  task automatic send_chord(logic signed [CHORD_W-1:0] chord, logic [COUNT_W-1:0] count,
                            logic [NUM_SLOTS-1:0][CHAR_W-1:0] tweaks);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      start = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_chord_number = chord;
    in_tweak_count  = count;
    in_tweak_0      = tweaks[0];
    in_tweak_1      = tweaks[1];
    in_tweak_2      = tweaks[2];
    in_tweak_3      = tweaks[3];
    in_tweak_4      = tweaks[4];
    in_tweak_5      = tweaks[5];
    in_tweak_6      = tweaks[6];
    start           = 1'b1;
    do @(posedge clk); while (busy);
    @(negedge clk);
    predict_voicing(chord, count, tweaks);
  endtask

  // tweak slots from text; slots past the text get random bytes
  task automatic send_text(logic signed [CHORD_W-1:0] chord, logic [COUNT_W-1:0] count,
                           string text);
    logic [NUM_SLOTS-1:0][CHAR_W-1:0] tweaks;
    int i;
    for (i = 0; i < NUM_SLOTS; i++)
      tweaks[i] = (i < text.len()) ? text[i] : CHAR_W'($urandom_range(0, 255));
    send_chord(chord, count, tweaks);
  endtask

  // stop sending and let every expected word arrive
  task automatic wait_idle();
    start = 1'b0;
    while (expected_voices.size() != 0)
      @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // register write while idle
  task automatic write_register(logic [CFGIX_W-1:0] index, logic [CFG_W-1:0] data);
    cfg_we    = 1'b1;
    cfg_index = index;
    cfg_data  = data;
    @(negedge clk);
    cfg_we = 1'b0;
    if (index == REG_KEY)
      key_mirror = data;
    else if (index == REG_MODE)
      mode_mirror = data;
  endtask

  // result checker
  always @(posedge clk) begin
    voice_t want;
    voice_t got;
    if (rst_n && out_valid) begin
      got = {out_root_pitch, out_note_offset, out_slot_index, out_is_rest,
             out_bad_tweak, out_last};
      if (expected_voices.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= REPORT_MAX)
          $display("unexpected word: root %0d offset %0d slot %0d rest %b bad %b last %b",
                   $signed(got.root), $signed(got.offset), got.slot, got.rest, got.bad,
                   got.last);
      end else begin
        want = expected_voices.pop_front();
        if (got !== want) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_MAX) begin
            $display("mismatch: expected root %0d offset %0d slot %0d rest %b bad %b last %b",
                     $signed(want.root), $signed(want.offset), want.slot, want.rest,
                     want.bad, want.last);
            $display("          actual   root %0d offset %0d slot %0d rest %b bad %b last %b",
                     $signed(got.root), $signed(got.offset), got.slot, got.rest, got.bad,
                     got.last);
          end
        end
      end
    end
  end

  // defaults straight out of reset
  task automatic test_reset_state();
    send_text(1, 7, "xxxxxxx");
    send_text(4, 3, "nmx");
  endtask

  // every tweak character, skips, rests and field extremes
  task automatic test_tweak_decode();
    send_text(1, 7, "xXsSuUb");
    send_text(5, 7, "BdDnNmM");
    send_text(3, 7, "lLpPqQr");
    send_text(7, 7, "RyYxLPn");
    // unknown characters, all-zero and all-one bytes among them
    send_chord(2, 7, {8'h80, "-", "Y", "z", 8'h7F, 8'hFF, 8'h00});
    // no slots in use gives a rest
    send_text(2, 0, "");
    // every used slot skipped gives a rest
    send_text(6, 3, "---");
    // only the used slots count
    send_text(3, 2, "x-");
    send_text(-32, 7, "rrRrrrQ");
    send_text(31, 7, "LLLlLML");
    send_text(-7, 7, "pqrnmlx");
    send_text(21, 7, "NMLPQRX");
    send_text(0, 5, "-x-X-");
    wait_idle();
    write_register(REG_KEY, 4'd11);
    write_register(REG_MODE, 4'd9);
    send_text(-32, 7, "rpqxnml");
    send_text(31, 7, "LMNXRQP");
    send_text(1, 1, "?");
    wait_idle();
    write_register(REG_KEY, 4'd15);
    write_register(REG_MODE, 4'd15);
    send_text(1, 7, "xnmlpqr");
    send_text(14, 4, "-b-B");
  endtask

  // writes to undecoded indexes leave both registers alone
  task automatic test_spare_registers();
    wait_idle();
    write_register(REG_KEY, 4'd7);
    write_register(REG_MODE, 4'd6);
    write_register(REG_SPARE_A, 4'hF);
    write_register(REG_SPARE_B, 4'h9);
    send_text(4, 7, "xnmlsud");
    send_text(-3, 2, "Xq");
  endtask

  // random chords over a series of register settings
  task automatic test_random_voicings();
    logic [NUM_SLOTS-1:0][CHAR_W-1:0] tweaks;
    logic signed [CHORD_W-1:0]        chord;
    logic [COUNT_W-1:0]               count;
    int p;
    int k;
    int i;
    int r;
    for (p = 0; p < 12; p++) begin
      wait_idle();
      case (p)
        0:       write_register(REG_KEY, 4'd0);
        1:       write_register(REG_KEY, 4'd11);
        2:       write_register(REG_KEY, 4'd15);
        3:       write_register(REG_KEY, 4'd12);
        default: write_register(REG_KEY, CFG_W'($urandom_range(0, 15)));
      endcase
      if (p < MODE_ROWS)
        write_register(REG_MODE, CFG_W'(p));
      else if (p == MODE_ROWS)
        write_register(REG_MODE, 4'd15);
      else
        write_register(REG_MODE, CFG_W'($urandom_range(10, 14)));
      if ($urandom_range(0, 3) == 0)
        write_register($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B,
                       CFG_W'($urandom_range(0, 15)));
      for (k = 0; k < 13; k++) begin
        // mostly in-range degrees, some anywhere in the field
        if ($urandom_range(0, 9) < 8)
          chord = CHORD_W'($urandom_range(0, 28) - 7);
        else
          chord = CHORD_W'($urandom_range(0, 63) - 32);
        count = ($urandom_range(0, 2) == 0) ? COUNT_W'($urandom_range(0, 7)) : 3'd7;
        // mostly known tweaks, some skips and raw bytes
        for (i = 0; i < NUM_SLOTS; i++) begin
          r = $urandom_range(0, 99);
          if (r < 70)
            tweaks[i] = known_tweaks[$urandom_range(0, known_tweaks.len() - 1)];
          else if (r < 82)
            tweaks[i] = SKIP_CHAR;
          else
            tweaks[i] = CHAR_W'($urandom_range(0, 255));
        end
        // now and then hold off until the block has drained
        if ($urandom_range(0, 19) == 0)
          wait_idle();
        send_chord(chord, count, tweaks);
      end
    end
  endtask

  // stimulus sequence
  initial begin
    int waited;
    clk             = 1'b0;
    rst_n           = 1'b0;
    start           = 1'b0;
    in_chord_number = '0;
    in_tweak_count  = '0;
    in_tweak_0      = '0;
    in_tweak_1      = '0;
    in_tweak_2      = '0;
    in_tweak_3      = '0;
    in_tweak_4      = '0;
    in_tweak_5      = '0;
    in_tweak_6      = '0;
    cfg_we          = 1'b0;
    cfg_index       = '0;
    cfg_data        = '0;
    key_mirror      = '0;
    mode_mirror     = '0;
    mismatch_count  = 0;
    cycle_count     = 0;
    repeat (5) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    test_reset_state();
    test_tweak_decode();
    test_spare_registers();
    test_random_voicings();

    // drain and settle
    start  = 1'b0;
    waited = 0;
    while (expected_voices.size() != 0 && waited < DRAIN_MAX) begin
      @(negedge clk);
      waited++;
    end
    mismatch_count += expected_voices.size();
    repeat (10) @(negedge clk);
    if (mismatch_count == 0)
      $display("scale_chord_voicer verification clean");
    else
      $display("scale_chord_voicer verification failed");
    $finish;
  end

endmodule
